[design/helmert_seven_param_transform_core_macros.svh]
// assertion macros for the helmert transform core
`ifndef HELMERT_SEVEN_PARAM_TRANSFORM_CORE_MACROS_SVH
`define HELMERT_SEVEN_PARAM_TRANSFORM_CORE_MACROS_SVH
// same-cycle implication, off while reset is applied
`define HSP_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("hsp check failed: same-cycle rule");
// next-cycle implication, off while reset is applied
`define HSP_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("hsp check failed: next-cycle rule");
`endif

[design/hsp_pkg.sv]
// shared constants for the helmert transform core
`default_nettype none
package hsp_pkg;
	localparam int PARAM_W = 24;
	localparam int CFG_DATA_W = PARAM_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 3'd7;

	// scale: floor(2^92 / 1e9), rotation: floor(pi*2^61 * 2^34 / 648e9)
	localparam int KS_EXP = 92;
	localparam int KR_EXP = 95;
	localparam int KS_W = 64;
	localparam int KR_W = 59;
	localparam logic [127:0] KS_WIDE = (128'd1 << KS_EXP) / 128'd1000000000;
	localparam logic [127:0] KR_WIDE = (128'h6487ED5110B4611A << 34) / 128'd648000000000;
	localparam logic signed [KS_W-1:0] KS = KS_WIDE[KS_W-1:0];
	localparam logic signed [KR_W-1:0] KR = KR_WIDE[KR_W-1:0];

	// latency of the split multiplier
	localparam int MUL_LAT = 2;

	// point queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam logic [Q_PTR_W:0] Q_FULL = 3'd4;
endpackage
`default_nettype wire

[design/hsp_ifs.sv]
// point and result stream interfaces
`default_nettype none
interface hsp_point_if #(parameter int COORD_BITS = 34);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] x_in;
	logic signed [COORD_BITS-1:0] y_in;
	logic signed [COORD_BITS-1:0] z_in;
	modport source (output valid, x_in, y_in, z_in, input ready);
	modport sink (input valid, x_in, y_in, z_in, output ready);
endinterface

interface hsp_result_if #(parameter int COORD_BITS = 34);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] x_out;
	logic signed [COORD_BITS-1:0] y_out;
	logic signed [COORD_BITS-1:0] z_out;
	logic saturated;
	modport source (output valid, x_out, y_out, z_out, saturated, input ready);
	modport sink (input valid, x_out, y_out, z_out, saturated, output ready);
endinterface
`default_nettype wire

[design/hsp_mul.sv]
// two-stage signed multiplier built from four half-width partial products
`default_nettype none
module hsp_mul #(
	parameter int AW = 25,
	parameter int BW = 64
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic signed [AL:0]   a_lo;
	logic signed [AH-1:0] a_hi;
	logic signed [BL:0]   b_lo;
	logic signed [BH-1:0] b_hi;

	logic signed [AL+BL+1:0] ll_s1;
	logic signed [AL+BH:0]   lh_s1;
	logic signed [AH+BL:0]   hl_s1;
	logic signed [AH+BH-1:0] hh_s1;

	logic signed [PW-1:0] outer;
	logic signed [PW-1:0] mid_lh;
	logic signed [PW-1:0] mid_hl;
	logic signed [PW-1:0] p_s2;

	assign a_lo = {1'b0, a[AL-1:0]};
	assign a_hi = a[AW-1:AL];
	assign b_lo = {1'b0, b[BL-1:0]};
	assign b_hi = b[BW-1:BL];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a_lo * b_lo;
			lh_s1 <= a_lo * b_hi;
			hl_s1 <= a_hi * b_lo;
			hh_s1 <= a_hi * b_hi;
		end
	end

	// low product is non-negative and below 2^(AL+BL), so it packs under the high one
	always_comb begin
		outer = {hh_s1, ll_s1[AL+BL-1:0]};
		mid_lh = PW'(lh_s1) <<< BL;
		mid_hl = PW'(hl_s1) <<< AL;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= outer + mid_lh + mid_hl;
		end
	end

	assign p = p_s2;
endmodule
`default_nettype wire

[design/hsp_coef.sv]
// register file and coefficient pipeline that builds the rotation-scale matrix
`default_nettype none
module hsp_coef #(
	parameter int FRAC_BITS = 46
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              ready,
	output logic signed [FRAC_BITS+1:0]       factor [3][3],
	output logic signed [hsp_pkg::PARAM_W:0]  shift [3]
);
	localparam int KW = FRAC_BITS + 2;
	localparam int EW = hsp_pkg::PARAM_W + 1;
	localparam int SPW = EW + hsp_pkg::KS_W;
	localparam int RPW = EW + hsp_pkg::KR_W;
	localparam int OPW = 2 * KW;
	localparam int SSH = hsp_pkg::KS_EXP - FRAC_BITS;
	localparam int RSH = hsp_pkg::KR_EXP - FRAC_BITS;
	localparam int SETTLE = 2 * hsp_pkg::MUL_LAT + 4;
	localparam int SETTLE_W = $clog2(SETTLE + 1);
	localparam logic [SETTLE_W-1:0] SETTLE_CNT = SETTLE_W'(SETTLE);

	localparam logic signed [SPW-1:0] HALF_S = SPW'(1) <<< (SSH - 1);
	localparam logic signed [RPW-1:0] HALF_R = RPW'(1) <<< (RSH - 1);
	localparam logic signed [OPW-1:0] HALF_O = OPW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [KW-1:0]  KQ_ONE = {2'b01, {FRAC_BITS{1'b0}}};

	function automatic logic signed [hsp_pkg::PARAM_W:0] apply_sign(
		input logic signed [hsp_pkg::PARAM_W-1:0] v,
		input logic neg
	);
		logic signed [hsp_pkg::PARAM_W:0] ext;
		ext = v;
		return neg ? -ext : ext;
	endfunction

	logic signed [hsp_pkg::PARAM_W-1:0] shift_q [3];
	logic signed [hsp_pkg::PARAM_W-1:0] rot_q [3];
	logic signed [hsp_pkg::PARAM_W-1:0] scale_q;
	logic                               inverse_q;
	logic [SETTLE_W-1:0]                settle_q;

	logic signed [EW-1:0]  scale_e;
	logic signed [EW-1:0]  rot_e [3];
	logic signed [SPW-1:0] scale_p;
	logic signed [RPW-1:0] rot_p [3];
	logic signed [SPW-1:0] scale_sum;
	logic signed [SPW-1:0] scale_sh;
	logic signed [RPW-1:0] rot_sum [3];
	logic signed [RPW-1:0] rot_sh [3];

	logic signed [KW-1:0]  scale_rnd_s1;
	logic signed [KW-1:0]  rot_rnd_s1 [3];
	logic signed [KW-1:0]  kq_s2;
	logic signed [KW-1:0]  rot_s2 [3];

	logic signed [OPW-1:0] off_p [3];
	logic signed [OPW-1:0] off_sum [3];
	logic signed [OPW-1:0] off_sh [3];
	logic signed [KW-1:0]  off_v [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				shift_q[i] <= '0;
				rot_q[i] <= '0;
			end
			scale_q <= '0;
			inverse_q <= 1'b0;
			settle_q <= SETTLE_CNT;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CNT;
			unique case (cfg_index)
				hsp_pkg::REG_SHIFT_X: shift_q[0] <= cfg_data;
				hsp_pkg::REG_SHIFT_Y: shift_q[1] <= cfg_data;
				hsp_pkg::REG_SHIFT_Z: shift_q[2] <= cfg_data;
				hsp_pkg::REG_ROT_X:   rot_q[0] <= cfg_data;
				hsp_pkg::REG_ROT_Y:   rot_q[1] <= cfg_data;
				hsp_pkg::REG_ROT_Z:   rot_q[2] <= cfg_data;
				hsp_pkg::REG_SCALE:   scale_q <= cfg_data;
				hsp_pkg::REG_INVERSE: inverse_q <= cfg_data[0];
			endcase
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	assign ready = (settle_q == '0);

	always_comb begin
		scale_e = apply_sign(scale_q, inverse_q);
		for (int i = 0; i < 3; i++) begin
			rot_e[i] = apply_sign(rot_q[i], inverse_q);
			shift[i] = apply_sign(shift_q[i], inverse_q);
		end
	end

	hsp_mul #(.AW(EW), .BW(hsp_pkg::KS_W)) u_scale_mul (
		.clk (clk),
		.en  (1'b1),
		.a   (scale_e),
		.b   (hsp_pkg::KS),
		.p   (scale_p)
	);

	for (genvar i = 0; i < 3; i++) begin : g_rot
		hsp_mul #(.AW(EW), .BW(hsp_pkg::KR_W)) u_rot_mul (
			.clk (clk),
			.en  (1'b1),
			.a   (rot_e[i]),
			.b   (hsp_pkg::KR),
			.p   (rot_p[i])
		);
	end

	// round half up, then drop to the Q2.F factor width
	always_comb begin
		scale_sum = scale_p + HALF_S;
		scale_sh = scale_sum >>> SSH;
		for (int i = 0; i < 3; i++) begin
			rot_sum[i] = rot_p[i] + HALF_R;
			rot_sh[i] = rot_sum[i] >>> RSH;
		end
	end

	always_ff @(posedge clk) begin
		scale_rnd_s1 <= scale_sh[KW-1:0];
		kq_s2 <= KQ_ONE + scale_rnd_s1;
		for (int i = 0; i < 3; i++) begin
			rot_rnd_s1[i] <= rot_sh[i][KW-1:0];
			rot_s2[i] <= rot_rnd_s1[i];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_off
		hsp_mul #(.AW(KW), .BW(KW)) u_off_mul (
			.clk (clk),
			.en  (1'b1),
			.a   (kq_s2),
			.b   (rot_s2[i]),
			.p   (off_p[i])
		);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_sum[i] = off_p[i] + HALF_O;
			off_sh[i] = off_sum[i] >>> FRAC_BITS;
			off_v[i] = off_sh[i][KW-1:0];
		end
	end

	// off_v holds k*rx, k*ry, k*rz
	always_ff @(posedge clk) begin
		factor[0][0] <= kq_s2;
		factor[0][1] <= off_v[2];
		factor[0][2] <= -off_v[1];
		factor[1][0] <= -off_v[2];
		factor[1][1] <= kq_s2;
		factor[1][2] <= off_v[0];
		factor[2][0] <= off_v[1];
		factor[2][1] <= -off_v[0];
		factor[2][2] <= kq_s2;
	end
endmodule
`default_nettype wire

[design/hsp_front.sv]
// input side: takes points once the matrix is settled and queues them for the back end
`default_nettype none
module hsp_front #(
	parameter int COORD_BITS = 34
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        coef_ready,
	hsp_point_if.sink   points,
	hsp_point_if.source pending
);
	logic signed [COORD_BITS-1:0] x_mem [hsp_pkg::Q_DEPTH];
	logic signed [COORD_BITS-1:0] y_mem [hsp_pkg::Q_DEPTH];
	logic signed [COORD_BITS-1:0] z_mem [hsp_pkg::Q_DEPTH];
	logic [hsp_pkg::Q_PTR_W-1:0]  wr_q;
	logic [hsp_pkg::Q_PTR_W-1:0]  rd_q;
	logic [hsp_pkg::Q_PTR_W:0]    count_q;
	logic                         push;
	logic                         pop;

	assign points.ready = coef_ready && (count_q != hsp_pkg::Q_FULL);
	assign push = points.valid && points.ready;
	assign pop = pending.valid && pending.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			x_mem[wr_q] <= points.x_in;
			y_mem[wr_q] <= points.y_in;
			z_mem[wr_q] <= points.z_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign pending.valid = (count_q != '0);
	assign pending.x_in = x_mem[rd_q];
	assign pending.y_in = y_mem[rd_q];
	assign pending.z_in = z_mem[rd_q];
endmodule
`default_nettype wire

[design/hsp_back.sv]
// back end: matrix multiply, translation, rounding and saturation pipeline
`default_nettype none
module hsp_back #(
	parameter int COORD_BITS = 34,
	parameter int FRAC_BITS = 46
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [FRAC_BITS+1:0]      factor [3][3],
	input  logic signed [hsp_pkg::PARAM_W:0] shift [3],
	hsp_point_if.sink                        pending,
	hsp_result_if.source                     results
);
	localparam int KW = FRAC_BITS + 2;
	localparam int MW = KW + COORD_BITS;
	localparam int AW = MW + 2;
	localparam int RW = AW - FRAC_BITS;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [COORD_BITS-1:0] c_s1 [3];
	logic signed [MW-1:0]         prod [3][3];
	logic signed [AW-1:0]         sh_term [3];
	logic signed [AW-1:0]         pair_s4 [3];
	logic signed [AW-1:0]         third_s4 [3];
	logic signed [AW-1:0]         total [3];
	logic signed [AW-1:0]         total_sh [3];
	logic signed [RW-1:0]         rv_s5 [3];
	logic [RW-COORD_BITS:0]       top_bits [3];
	logic signed [COORD_BITS-1:0] sat_v [3];
	logic [2:0]                   clip;

	// whole pipeline moves unless a finished word is stuck at the output
	assign advance = !results.valid || results.ready;
	assign pending.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			results.valid <= 1'b0;
		end else if (advance) begin
			v_s1 <= pending.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			results.valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			c_s1[0] <= pending.x_in;
			c_s1[1] <= pending.y_in;
			c_s1[2] <= pending.z_in;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			hsp_mul #(.AW(KW), .BW(COORD_BITS)) u_mul (
				.clk (clk),
				.en  (advance),
				.a   (factor[i][j]),
				.b   (c_s1[j]),
				.p   (prod[i][j])
			);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_term[i] = AW'(shift[i]) <<< FRAC_BITS;
			total[i] = pair_s4[i] + third_s4[i];
			total_sh[i] = total[i] >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				pair_s4[i] <= AW'(prod[i][0]) + AW'(prod[i][1]);
				third_s4[i] <= AW'(prod[i][2]) + sh_term[i] + HALF;
				rv_s5[i] <= total_sh[i][RW-1:0];
			end
		end
	end

	// in range when every bit from the coordinate sign upward agrees
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			top_bits[i] = rv_s5[i][RW-1:COORD_BITS-1];
			clip[i] = !((&top_bits[i]) || !(|top_bits[i]));
			if (clip[i]) begin
				sat_v[i] = rv_s5[i][RW-1] ? MINV : MAXV;
			end else begin
				sat_v[i] = rv_s5[i][COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			results.x_out <= sat_v[0];
			results.y_out <= sat_v[1];
			results.z_out <= sat_v[2];
			results.saturated <= |clip;
		end
	end
endmodule
`default_nettype wire

[design/helmert_seven_param_transform_core.sv]
// Helmert seven-parameter datum shift (small-angle form) on a stream of Cartesian points in
// millimetres. The block takes one point per clock while points.ready is high, and returns its
// transformed point through the back pipeline: one queue read stage, the two-stage split
// multipliers (nine of them, one per matrix element), a partial-sum stage, a rounding stage and
// the saturating output register. A four-word queue sits between the input side and that
// pipeline, so new points are still taken while a finished word waits at the output, until the
// queue is full. The rotation-scale matrix is computed from the registers by its own pipeline;
// after reset and after every register write the points channel holds ready low while that
// pipeline settles. The user must write registers only while no point is in flight; the block
// itself does not enforce this.
`default_nettype none
`include "helmert_seven_param_transform_core_macros.svh"
module helmert_seven_param_transform_core #(
	parameter int COORD_BITS = 34,
	parameter int FRAC_BITS = 46
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsp_pkg::CFG_DATA_W-1:0] cfg_data,
	hsp_point_if.sink                      points,
	hsp_result_if.source                   results
);
	localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	hsp_point_if #(.COORD_BITS(COORD_BITS)) pending ();

	logic                             coef_ready;
	logic signed [FRAC_BITS+1:0]      factor [3][3];
	logic signed [hsp_pkg::PARAM_W:0] shift [3];
	logic                             at_bound;

	hsp_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ready     (coef_ready),
		.factor    (factor),
		.shift     (shift)
	);

	hsp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_ready (coef_ready),
		.points     (points),
		.pending    (pending)
	);

	hsp_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.factor  (factor),
		.shift   (shift),
		.pending (pending),
		.results (results)
	);

	assign at_bound = results.x_out == CMAX || results.x_out == CMIN
		|| results.y_out == CMAX || results.y_out == CMIN
		|| results.z_out == CMAX || results.z_out == CMIN;

	// a register write must hold off new points while the matrix is rebuilt
	`HSP_ASSERT_NEXT(a_cfg_holds_input, cfg_we, !points.ready)
	// a clipped word carries at least one coordinate on a range bound
	`HSP_ASSERT_NOW(a_sat_at_bound, results.valid && results.saturated, at_bound)
	// the back end must not draw from the queue while its output word is stuck
	`HSP_ASSERT_NOW(a_stall_no_pop, results.valid && !results.ready, !pending.ready)
endmodule
`default_nettype wire

[verif/tb_helmert_seven_param_transform_core.sv]
// testbench for the helmert seven-parameter transform core: directed table, random phases
module tb_helmert_seven_param_transform_core;
	import hsp_pkg::*;

	localparam int COORD_W = 34;
	localparam int FRAC_W = 46;
	localparam int NUM_PHASES = 13;
	localparam int PHASE_ITEMS = 150;
	localparam int PRESSURE_PHASE = 5;
	localparam int LONG_HOLD = 200;
	localparam int TAIL_CYCLES = 24;
	localparam int CYCLE_LIMIT = 1500000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [127:0] wide_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_word_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		bit sat;
	} point_t;

	typedef struct {
		bit is_cfg;
		cfg_idx_t idx;
		cfg_word_t data;
		coord_t x;
		coord_t y;
		coord_t z;
		bit typed;
		point_t want;
	} stim_row_t;

	localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};
	// scale factor floor(2^92/1e9), rotation factor floor(pi*2^61 * 2^34 / 648e9)
	localparam wide_t SCALE_K = (128'd1 << 92) / 128'd1000000000;
	localparam wide_t ROT_K = (128'h6487ED5110B4611A << 34) / 128'd648000000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	cfg_idx_t cfg_index;
	cfg_word_t cfg_data;

	hsp_point_if #(.COORD_BITS(COORD_W)) pts ();
	hsp_result_if #(.COORD_BITS(COORD_W)) res ();

	helmert_seven_param_transform_core #(
		.COORD_BITS(COORD_W),
		.FRAC_BITS(FRAC_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.points(pts),
		.results(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register copies used for prediction
	logic signed [CFG_DATA_W-1:0] shift_cp [3];
	logic signed [CFG_DATA_W-1:0] rot_cp [3];
	logic signed [CFG_DATA_W-1:0] scale_cp;
	bit inverse_cp;

	point_t due_points [$];
	stim_row_t dir_rows [$];
	int mismatches = 0;
	int unexpected = 0;
	int points_checked = 0;
	int sat_results = 0;
	int input_stalls = 0;
	int settings_used = 0;
	int hold_requests = 0;
	int cycle_count = 0;
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;

	function automatic wide_t round_shift(wide_t v, int n);
		return (v + (wide_t'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic point_t helmert_predict(coord_t xi, coord_t yi, coord_t zi);
		wide_t sgn, kq, acc, v;
		wide_t off [3];
		wide_t c [3];
		wide_t m [3][3];
		coord_t o [3];
		point_t p;
		bit clip;
		clip = 1'b0;
		sgn = inverse_cp ? -1 : 1;
		kq = (wide_t'(1) <<< FRAC_W) + round_shift(sgn * wide_t'(scale_cp) * SCALE_K, 92 - FRAC_W);
		for (int i = 0; i < 3; i++) begin
			v = round_shift(sgn * wide_t'(rot_cp[i]) * ROT_K, 95 - FRAC_W);
			off[i] = round_shift(kq * v, FRAC_W);
		end
		c[0] = wide_t'(xi);
		c[1] = wide_t'(yi);
		c[2] = wide_t'(zi);
		// small-angle rotation matrix scaled by k
		m[0][0] = kq;      m[0][1] = off[2];  m[0][2] = -off[1];
		m[1][0] = -off[2]; m[1][1] = kq;      m[1][2] = off[0];
		m[2][0] = off[1];  m[2][1] = -off[0]; m[2][2] = kq;
		for (int i = 0; i < 3; i++) begin
			acc = sgn * wide_t'(shift_cp[i]) * (wide_t'(1) <<< FRAC_W);
			for (int j = 0; j < 3; j++)
				acc = acc + m[i][j] * c[j];
			v = round_shift(acc, FRAC_W);
			if (v > wide_t'(CMAX)) begin
				o[i] = CMAX;
				clip = 1'b1;
			end else if (v < wide_t'(CMIN)) begin
				o[i] = CMIN;
				clip = 1'b1;
			end else begin
				o[i] = coord_t'(v);
			end
		end
		p.x = o[0];
		p.y = o[1];
		p.z = o[2];
		p.sat = clip;
		return p;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 80);
	endfunction

	function automatic coord_t rand_coord();
		longint v;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			if ($urandom_range(0, 1))
				v = longint'(CMAX) - longint'($urandom_range(0, 3000));
			else
				v = longint'(CMIN) + longint'($urandom_range(0, 3000));
		end else if (pick <= 3) begin
			v = longint'($urandom_range(0, 2000000)) - 1000000;
		end else if (pick <= 6) begin
			// earth-sized coordinates
			v = longint'({$urandom(), $urandom()} % 64'd12800000001) - longint'(64'd6400000000);
		end else begin
			v = longint'({$urandom(), $urandom()});
		end
		return coord_t'(v);
	endfunction

	function automatic cfg_word_t rand_param();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 24'h7FFFFF;
		else if (pick == 1)
			return 24'h800000;
		else if (pick == 2)
			return '0;
		else if (pick <= 5)
			return cfg_word_t'(longint'($urandom_range(0, 2000)) - 1000);
		return cfg_word_t'($urandom());
	endfunction

	task automatic write_reg(cfg_idx_t idx, cfg_word_t data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SHIFT_X: shift_cp[0] = data;
			REG_SHIFT_Y: shift_cp[1] = data;
			REG_SHIFT_Z: shift_cp[2] = data;
			REG_ROT_X: rot_cp[0] = data;
			REG_ROT_Y: rot_cp[1] = data;
			REG_ROT_Z: rot_cp[2] = data;
			REG_SCALE: scale_cp = data;
			REG_INVERSE: inverse_cp = data[0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic offer_point(coord_t xi, coord_t yi, coord_t zi, int gap, bit typed, point_t want);
		repeat (gap) begin
			@(negedge clk);
			pts.valid <= 1'b0;
		end
		@(negedge clk);
		pts.valid <= 1'b1;
		pts.x_in <= xi;
		pts.y_in <= yi;
		pts.z_in <= zi;
		do @(posedge clk); while (!pts.ready);
		if (typed)
			due_points = {due_points, want};
		else
			due_points = {due_points, helmert_predict(xi, yi, zi)};
	endtask

	// drop valid and let every word in flight come out before registers change
	task automatic finish_batch();
		@(negedge clk);
		pts.valid <= 1'b0;
		wait (due_points.size() == 0);
		@(posedge clk);
	endtask

	task automatic add_cfg(cfg_idx_t idx, cfg_word_t data);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		dir_rows = {dir_rows, r};
	endtask

	task automatic add_pt(coord_t xi, coord_t yi, coord_t zi);
		stim_row_t r;
		r = '{default: '0};
		r.x = xi;
		r.y = yi;
		r.z = zi;
		dir_rows = {dir_rows, r};
	endtask

	task automatic add_typed(coord_t xi, coord_t yi, coord_t zi, coord_t ex, coord_t ey, coord_t ez,
			bit es);
		stim_row_t r;
		r = '{default: '0};
		r.x = xi;
		r.y = yi;
		r.z = zi;
		r.typed = 1'b1;
		r.want = '{x: ex, y: ey, z: ez, sat: es};
		dir_rows = {dir_rows, r};
	endtask

	task automatic note_error(string msg);
		if (mismatches + unexpected < 10)
			$display("%0d: %s", cycle_count, msg);
	endtask

	// result checker
	always @(posedge clk) begin
		point_t want;
		if (arst_n && pts.valid && !pts.ready)
			input_stalls++;
		if (arst_n && res.valid && res.ready) begin
			if (due_points.size() == 0) begin
				note_error($sformatf("result word with nothing expected: %0d %0d %0d sat %0b",
					res.x_out, res.y_out, res.z_out, res.saturated));
				unexpected++;
			end else begin
				want = due_points.pop_front();
				points_checked++;
				if (res.saturated === 1'b1)
					sat_results++;
				if (res.x_out !== want.x || res.y_out !== want.y || res.z_out !== want.z
						|| res.saturated !== want.sat) begin
					note_error($sformatf(
						"mismatch: expected %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
						want.x, want.y, want.z, want.sat,
						res.x_out, res.y_out, res.z_out, res.saturated));
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				due_points.size());
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin : result_sink
		int stall_left;
		int seen_holds;
		bit nxt;
		stall_left = 0;
		seen_holds = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != seen_holds) begin
				seen_holds = hold_requests;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = rand_gap();
			end
			if (stall_left > 0) begin
				nxt = 1'b0;
				stall_left--;
			end else begin
				nxt = 1'b1;
			end
			res.ready <= nxt;
		end
	end

	initial begin : stimulus
		point_t none;
		cfg_word_t v;
		int fails;
		none = '{default: '0};
		pts.valid = 1'b0;
		pts.x_in = '0;
		pts.y_in = '0;
		pts.z_in = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SHIFT_X;
		cfg_data = '0;
		for (int i = 0; i < 3; i++) begin
			shift_cp[i] = '0;
			rot_cp[i] = '0;
		end
		scale_cp = '0;
		inverse_cp = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity after reset
		add_typed(0, 0, 0, 0, 0, 0, 1'b0);
		add_typed(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0);
		add_typed(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0);
		add_typed(CMAX, CMIN, 0, CMAX, CMIN, 0, 1'b0);
		add_typed(-1, 1, -1, -1, 1, -1, 1'b0);
		add_typed(34'h1_5555_5555, 34'h2_AAAA_AAAA, 34'h0_F0F0_F0F0,
			34'h1_5555_5555, 34'h2_AAAA_AAAA, 34'h0_F0F0_F0F0, 1'b0);
		// pure translation, clipping at both bounds
		add_cfg(REG_SHIFT_X, 24'h7FFFFF);
		add_cfg(REG_SHIFT_Y, 24'h800000);
		add_cfg(REG_SHIFT_Z, 24'd5);
		add_typed(CMAX, CMIN, 0, CMAX, CMIN, 5, 1'b1);
		add_typed(0, 0, 0, 8388607, -8388608, 5, 1'b0);
		add_typed(CMIN, CMAX, CMAX, CMIN + 34'sd8388607, CMAX - 34'sd8388608, CMAX, 1'b1);
		// inverse: the most negative shift turns positive
		add_cfg(REG_INVERSE, 24'h000001);
		add_typed(0, 0, 0, -8388607, 8388608, -5, 1'b0);
		add_typed(CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, 1'b1);
		// full transform with extreme scale and rotations
		add_cfg(REG_SCALE, 24'h800000);
		add_cfg(REG_ROT_X, 24'h7FFFFF);
		add_cfg(REG_ROT_Y, 24'h800000);
		add_cfg(REG_ROT_Z, 24'h01E240);
		add_pt(CMAX, CMAX, CMAX);
		add_pt(CMIN, CMIN, CMIN);
		add_pt(34'sd6378137000, 0, 0);
		add_pt(34'sd1234567890, -34'sd987654321, 34'sd4000000000);
		// stray high bits on the inverse register, bit 0 clear then set
		add_cfg(REG_INVERSE, 24'hFFFFFE);
		add_pt(CMAX, CMIN, CMAX);
		add_pt(34'sd6378137000, 0, 0);
		add_pt(34'sd1234567890, -34'sd987654321, 34'sd4000000000);
		add_cfg(REG_INVERSE, 24'hABCDEF);
		add_pt(CMAX, CMIN, CMAX);
		add_pt(0, 34'sd6378137000, -34'sd6378137000);
		add_pt(34'sd1234567890, -34'sd987654321, 34'sd4000000000);

		settings_used = 1;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				finish_batch();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
				settings_used++;
			end else begin
				offer_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, 0,
					dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			finish_batch();
			for (int r = REG_SHIFT_X; r <= REG_SCALE; r++) begin
				if (p == 0 || p == 2)
					v = 24'h7FFFFF;
				else if (p == 1 || p == 3)
					v = 24'h800000;
				else
					v = rand_param();
				write_reg(cfg_idx_t'(r), v);
			end
			v = cfg_word_t'($urandom());
			if (p < 4)
				v[0] = (p == 1 || p == 2);
			write_reg(REG_INVERSE, v);
			settings_used++;

			tx_idle_on = (p % 4 != 3) && (p != PRESSURE_PHASE);
			rx_idle_on = (p % 4 != 3);
			if (p == PRESSURE_PHASE) begin
				// receiver holds off while the sender keeps offering
				@(posedge clk);
				hold_requests++;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_point(rand_coord(), rand_coord(), rand_coord(),
					(tx_idle_on && $urandom_range(0, 2) == 0) ? rand_gap() : 0, 1'b0, none);
		end

		finish_batch();
		repeat (TAIL_CYCLES) @(posedge clk);
		fails = mismatches + unexpected + due_points.size();
		$display("checked %0d transformed points across %0d register settings", points_checked,
			settings_used);
		$display("%0d clipped results, %0d input stall cycles, %0d mismatches, %0d stray results",
			sat_results, input_stalls, mismatches, unexpected);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[files.f]
+incdir+design
design/hsp_pkg.sv
design/hsp_ifs.sv
design/hsp_mul.sv
design/hsp_coef.sv
design/hsp_front.sv
design/hsp_back.sv
design/helmert_seven_param_transform_core.sv
verif/tb_helmert_seven_param_transform_core.sv
